/* sv/fqd_pkg.sv */
// Shared types, constants and helpers for the feedback queue dispatcher.
// Used by the core and the port checker.
`default_nettype none

package fqd_pkg;

   localparam int JOB_SLOTS = 64;
   localparam int LEVELS    = 4;
   localparam int LEVEL_W   = 2;
   localparam int SLOT_W    = (JOB_SLOTS > 1) ? $clog2(JOB_SLOTS) : 1;
   localparam int CNT_W     = $clog2(JOB_SLOTS + 1);
   localparam int ADDR_W    = LEVEL_W + SLOT_W;

   localparam int TAG_W = 8;
   localparam int RUN_W = 16;

   localparam int REQ_DATA_W = 32;
   localparam int REQ_USER_W = 1;
   localparam int RSP_DATA_W = 16;
   localparam int RSP_USER_W = 2;

   typedef enum logic [REQ_USER_W-1:0] {
      OP_SUBMIT = 1'b0,
      OP_TICK   = 1'b1
   } op_type;

   typedef enum logic [RSP_USER_W-1:0] {
      KIND_ACCEPT = 2'd0,
      KIND_REJECT = 2'd1,
      KIND_RAN    = 2'd2,
      KIND_IDLE   = 2'd3
   } result_kind_type;

   typedef struct packed {
      logic [TAG_W-1:0] tag;
      logic [RUN_W-1:0] run;
      logic [RUN_W-1:0] elapsed;
      logic             started;
   } job_entry_type;

   localparam int ENTRY_W = $bits(job_entry_type);

   typedef logic [SLOT_W-1:0] slot_type;
   typedef logic [CNT_W-1:0]  count_type;

   // Slot that lies count places after head, wrapped once around the ring.
   function automatic slot_type slot_add(input slot_type head, input count_type count);
      logic [SLOT_W:0] sum;
      begin
         sum = {1'b0, head} + (SLOT_W + 1)'(count);
         if (sum >= (SLOT_W + 1)'(JOB_SLOTS)) begin
            sum = sum - (SLOT_W + 1)'(JOB_SLOTS);
         end
         return sum[SLOT_W-1:0];
      end
   endfunction

endpackage : fqd_pkg

`default_nettype wire

/* sv/fqd_job_ram.sv */
// Single-port-write, single-port-read synchronous RAM holding the job entries.
// Read data is registered. No dependencies.
`default_nettype none

module fqd_job_ram #(
   parameter int ADDR_W = 8,
   parameter int DATA_W = 41
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [DATA_W-1:0] wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem [2**ADDR_W];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule : fqd_job_ram

`default_nettype wire

/* sv/feedback_queue_dispatcher_core.sv */
// Four-level feedback queue dispatcher: queue bookkeeping and tick sequencer.
// Depends on fqd_pkg and instantiates fqd_job_ram for the job entries.
//
// Usage. Requests arrive on the req_ stream: req_tuser selects a submit or a
// scheduling tick, req_tdata carries level, run length and tag of a submit.
// Every request beat yields exactly one response beat on the rsp_ stream;
// rsp_tuser gives the result kind, rsp_tdata the tag, start and done flags
// and the level the job sits at afterwards.
// A submit, or a tick that finds every level empty, responds in the next
// cycle after its beat is taken. A tick that runs a job reads the head entry
// from the job RAM and commits in the cycle after, registering its response
// then; the read-modify-write through the RAM's single read port sets this,
// so no request is taken while a tick commits, and submits every cycle.
// Responses sit in one output register; a new request is taken while no tick
// commits and that register is empty or being emptied in the same cycle, so
// a stalled receiver holds back the request side.
// Reset empties all levels and the output register; the job RAM is not
// cleared, as only entries that have been written are ever read.
`default_nettype none

module feedback_queue_dispatcher_core (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_tvalid,
   output logic                                  req_tready,
   // level[1:0], run_ticks[17:2], job_tag[25:18], zero above
   input  wire logic [fqd_pkg::REQ_DATA_W-1:0]   req_tdata,
   // op[0]
   input  wire logic [fqd_pkg::REQ_USER_W-1:0]   req_tuser,
   output logic                                  rsp_tvalid,
   input  wire logic                             rsp_tready,
   // ran_tag[7:0], fresh_start[8], job_done[9], next_level[11:10], zero above
   output logic      [fqd_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   // result_kind[1:0]
   output logic      [fqd_pkg::RSP_USER_W-1:0]   rsp_tuser
);

   import fqd_pkg::*;

   typedef enum logic {
      ST_IDLE,
      ST_COMMIT
   } state_type;

   state_type        state_ff, state_in;
   slot_type         heads_ff  [LEVELS];
   slot_type         heads_in  [LEVELS];
   count_type        counts_ff [LEVELS];
   count_type        counts_in [LEVELS];
   count_type        held_ff, held_in;
   logic [LEVEL_W-1:0] lv_ff, lv_in;

   logic              rsp_valid_ff, rsp_valid_in;
   result_kind_type   rsp_kind_ff, rsp_kind_in;
   logic [TAG_W-1:0]  rsp_tag_ff, rsp_tag_in;
   logic              rsp_fresh_ff, rsp_fresh_in;
   logic              rsp_done_ff, rsp_done_in;
   logic [LEVEL_W-1:0] rsp_level_ff, rsp_level_in;

   logic               out_free;
   logic               req_take;
   op_type             req_op;
   logic [LEVEL_W-1:0] req_level;
   logic [RUN_W-1:0]   req_run;
   logic [TAG_W-1:0]   req_tag;

   logic               any_busy;
   logic [LEVEL_W-1:0] pick_lv;

   logic               wr_en;
   logic [ADDR_W-1:0]  wr_addr;
   job_entry_type      wr_data;
   logic               rd_en;
   logic [ADDR_W-1:0]  rd_addr;
   logic [ENTRY_W-1:0] rd_raw;
   job_entry_type      rd_entry;
   job_entry_type      upd_entry;
   logic               run_done;
   logic               demote;
   logic [LEVEL_W-1:0] lv_next;

   fqd_job_ram #(
      .ADDR_W (ADDR_W),
      .DATA_W (ENTRY_W)
   ) u_job_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_raw)
   );

   assign req_op    = op_type'(req_tuser);
   assign req_level = req_tdata[1:0];
   assign req_run   = req_tdata[17:2];
   assign req_tag   = req_tdata[25:18];

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE) && out_free;
   assign req_take   = req_tvalid && req_tready;

   always_comb begin
      any_busy = 1'b1;
      pick_lv  = '0;
      priority if (counts_ff[0] != '0) begin
         pick_lv = LEVEL_W'(0);
      end else if (counts_ff[1] != '0) begin
         pick_lv = LEVEL_W'(1);
      end else if (counts_ff[2] != '0) begin
         pick_lv = LEVEL_W'(2);
      end else if (counts_ff[3] != '0) begin
         pick_lv = LEVEL_W'(3);
      end else begin
         any_busy = 1'b0;
      end
   end

   assign rd_entry = job_entry_type'(rd_raw);
   assign lv_next  = lv_ff + LEVEL_W'(1);

   always_comb begin
      upd_entry         = rd_entry;
      upd_entry.started = 1'b1;
      upd_entry.elapsed = rd_entry.elapsed + RUN_W'(1);
      run_done          = upd_entry.elapsed >= rd_entry.run;
      demote            = !run_done && (lv_ff == LEVEL_W'(1) || lv_ff == LEVEL_W'(2));
   end

   always_comb begin
      state_in     = state_ff;
      heads_in     = heads_ff;
      counts_in    = counts_ff;
      held_in      = held_ff;
      lv_in        = lv_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_kind_in  = rsp_kind_ff;
      rsp_tag_in   = rsp_tag_ff;
      rsp_fresh_in = rsp_fresh_ff;
      rsp_done_in  = rsp_done_ff;
      rsp_level_in = rsp_level_ff;
      wr_en        = 1'b0;
      wr_addr      = '0;
      wr_data      = '0;
      rd_en        = 1'b0;
      rd_addr      = {pick_lv, heads_ff[pick_lv]};

      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               if (req_op == OP_SUBMIT) begin
                  rsp_valid_in = 1'b1;
                  rsp_tag_in   = req_tag;
                  rsp_fresh_in = 1'b0;
                  rsp_done_in  = 1'b0;
                  rsp_level_in = req_level;
                  if (held_ff >= CNT_W'(JOB_SLOTS)) begin
                     rsp_kind_in = KIND_REJECT;
                  end else begin
                     rsp_kind_in = KIND_ACCEPT;
                     wr_en       = 1'b1;
                     wr_addr     = {req_level,
                                    slot_add(heads_ff[req_level], counts_ff[req_level])};
                     wr_data     = '{tag: req_tag, run: req_run, elapsed: '0,
                                     started: 1'b0};
                     counts_in[req_level] = counts_ff[req_level] + CNT_W'(1);
                     held_in     = held_ff + CNT_W'(1);
                  end
               end else if (!any_busy) begin
                  rsp_valid_in = 1'b1;
                  rsp_kind_in  = KIND_IDLE;
                  rsp_tag_in   = '0;
                  rsp_fresh_in = 1'b0;
                  rsp_done_in  = 1'b0;
                  rsp_level_in = '0;
               end else begin
                  rd_en    = 1'b1;
                  lv_in    = pick_lv;
                  state_in = ST_COMMIT;
               end
            end
         end
         ST_COMMIT: begin
            if (out_free) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
               rsp_kind_in  = KIND_RAN;
               rsp_tag_in   = rd_entry.tag;
               rsp_fresh_in = !rd_entry.started;
               rsp_done_in  = run_done;
               rsp_level_in = demote ? lv_next : lv_ff;
               if (run_done || demote) begin
                  heads_in[lv_ff]  = slot_add(heads_ff[lv_ff], CNT_W'(1));
                  counts_in[lv_ff] = counts_ff[lv_ff] - CNT_W'(1);
               end
               if (run_done) begin
                  held_in = held_ff - CNT_W'(1);
               end else if (demote) begin
                  wr_en   = 1'b1;
                  wr_addr = {lv_next, slot_add(heads_ff[lv_next], counts_ff[lv_next])};
                  wr_data = upd_entry;
                  counts_in[lv_next] = counts_ff[lv_next] + CNT_W'(1);
               end else begin
                  wr_en   = 1'b1;
                  wr_addr = {lv_ff, heads_ff[lv_ff]};
                  wr_data = upd_entry;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      lv_ff        <= lv_in;
      rsp_kind_ff  <= rsp_kind_in;
      rsp_tag_ff   <= rsp_tag_in;
      rsp_fresh_ff <= rsp_fresh_in;
      rsp_done_ff  <= rsp_done_in;
      rsp_level_ff <= rsp_level_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         heads_ff     <= '{default: '0};
         counts_ff    <= '{default: '0};
         held_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         heads_ff     <= heads_in;
         counts_ff    <= counts_in;
         held_ff      <= held_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tdata  = {4'b0000, rsp_level_ff, rsp_done_ff, rsp_fresh_ff, rsp_tag_ff};

endmodule : feedback_queue_dispatcher_core

`default_nettype wire

/* sv/fqd_checker.sv */
// Port-level checker for the feedback queue dispatcher core, with its bind.
// Depends on fqd_pkg; sees only the top-level ports.
`default_nettype none

module fqd_checker (
   input wire logic                           clock,
   input wire logic                           reset,
   input wire logic                           req_tvalid,
   input wire logic                           req_tready,
   input wire logic [fqd_pkg::REQ_DATA_W-1:0] req_tdata,
   input wire logic [fqd_pkg::REQ_USER_W-1:0] req_tuser,
   input wire logic                           rsp_tvalid,
   input wire logic                           rsp_tready,
   input wire logic [fqd_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input wire logic [fqd_pkg::RSP_USER_W-1:0] rsp_tuser
);

   import fqd_pkg::*;

   logic req_beat;

   assign req_beat = req_tvalid && req_tready;

   // A response beat that is stalled keeps its contents.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled response beat changed");

   // A submit is answered in the next cycle with its own tag and level.
   a_submit_reply: assert property (@(posedge clock) disable iff (reset)
      req_beat && req_tuser == OP_SUBMIT |=>
         rsp_tvalid && (rsp_tuser == KIND_ACCEPT || rsp_tuser == KIND_REJECT) &&
         rsp_tdata[7:0] == $past(req_tdata[25:18]) &&
         rsp_tdata[11:10] == $past(req_tdata[1:0]))
      else $error("submit beat not answered as expected");

   // A tick either answers idle at once or leaves the response register empty.
   a_tick_reply: assert property (@(posedge clock) disable iff (reset)
      req_beat && req_tuser == OP_TICK |=> !rsp_tvalid || rsp_tuser == KIND_IDLE)
      else $error("unexpected response after tick beat");

   // No request is taken while a response waits on a stalled receiver.
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      req_tready && rsp_tvalid |-> rsp_tready)
      else $error("request taken while response stalled");

   // An idle tick carries no job information.
   a_idle_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == KIND_IDLE |-> rsp_tdata == '0)
      else $error("idle tick response carries data");

endmodule : fqd_checker

bind feedback_queue_dispatcher_core fqd_checker u_fqd_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

`default_nettype wire
